FILE: rtl/rlu_pkg.sv
package rlu_pkg;

	localparam int CLASSES     = 4;
	localparam int PROB_W      = 16;
	localparam int SUP_W       = 16;
	localparam int FACT_W      = SUP_W;
	localparam int WEIGHT_W    = PROB_W + FACT_W - 1;
	localparam int SUM_W       = WEIGHT_W + $clog2(CLASSES);
	localparam int QUO_W       = PROB_W + 1;
	localparam int DIV_STAGES  = QUO_W;
	localparam int PIPE_STAGES = 2 + DIV_STAGES;
	localparam int DENS_W      = 16;
	localparam int CLS_W       = $clog2(CLASSES);
	localparam int CFG_IDX_W   = 8;

	localparam logic signed [SUP_W-1:0] Q_ONE     = SUP_W'(1 << (SUP_W - 2));
	localparam logic signed [SUP_W-1:0] Q_NEG_ONE = -Q_ONE;

	typedef logic [PROB_W-1:0]          prob_t;
	typedef logic signed [SUP_W-1:0]    sup_t;
	typedef logic [FACT_W-1:0]          fact_t;
	typedef logic [WEIGHT_W-1:0]        weight_t;
	typedef logic [SUM_W-1:0]           sum_t;
	typedef logic signed [DENS_W-1:0]   dens_t;
	typedef logic [CLS_W-1:0]           cls_t;
	typedef logic [CLASSES-1:0][PROB_W-1:0] prob_vec_t;
	typedef logic [CLASSES-1:0][DENS_W-1:0] dens_vec_t;

	typedef struct packed {
		prob_vec_t prob;
		cls_t      best;
		dens_t     density;
		logic      zero;
	} result_t;

	// support clamped to -1..1, then offset by one
	function automatic fact_t clamp_factor(sup_t s);
		sup_t                   c;
		logic signed [SUP_W:0]  t;
		c = s;
		if (s < Q_NEG_ONE) begin
			c = Q_NEG_ONE;
		end else if (s > Q_ONE) begin
			c = Q_ONE;
		end
		t = $signed({c[SUP_W-1], c}) + $signed({Q_ONE[SUP_W-1], Q_ONE});
		return t[FACT_W-1:0];
	endfunction

endpackage

FILE: rtl/relaxation_label_update_top.sv
// Relaxation labeling update: one pixel per beat, four class probabilities and supports in,
// renormalized probabilities, winning class and its density level out. Accepts one beat per
// cycle while in_stall is low. A beat passes the per-class weight multiply register, the
// weight sum register, the per-class restoring quotient pipeline (one quotient bit per stage)
// and the output register, where the argmax is registered. Bubbles in the pipeline are
// squeezed out under output stall, so input keeps flowing until every stage is full. Density
// levels are written through the cfg port, which is always ready; write them only while no
// beat is in flight.
module relaxation_label_update_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [15:0]                      prob_0,
	input  logic [15:0]                      prob_1,
	input  logic [15:0]                      prob_2,
	input  logic [15:0]                      prob_3,
	input  logic signed [15:0]               support_0,
	input  logic signed [15:0]               support_1,
	input  logic signed [15:0]               support_2,
	input  logic signed [15:0]               support_3,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [15:0]                      new_prob_0,
	output logic [15:0]                      new_prob_1,
	output logic [15:0]                      new_prob_2,
	output logic [15:0]                      new_prob_3,
	output logic [rlu_pkg::CLS_W-1:0]        best_class,
	output logic signed [15:0]               density_out,
	output logic                             zero_sum,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [rlu_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [15:0]                      cfg_data
);

	localparam int NC = rlu_pkg::CLASSES;
	localparam int NP = rlu_pkg::PIPE_STAGES;
	localparam int ND = rlu_pkg::DIV_STAGES;

	rlu_pkg::prob_t     prob_in [NC];
	rlu_pkg::sup_t      sup_in  [NC];
	rlu_pkg::weight_t   w_s1    [NC];
	rlu_pkg::weight_t   w_s2    [NC];
	rlu_pkg::sum_t      sum_s1;
	rlu_pkg::sum_t      sum_s2;
	logic               zero_s2;
	logic               zero_div_s [ND];
	rlu_pkg::prob_vec_t quo;
	rlu_pkg::dens_vec_t dens_q;
	rlu_pkg::result_t   merged;
	rlu_pkg::result_t   res_q;
	logic [NP-1:0]      vld_q;
	logic [NP:0]        rdy;
	logic               best_ok;

	assign prob_in[0] = prob_0;
	assign prob_in[1] = prob_1;
	assign prob_in[2] = prob_2;
	assign prob_in[3] = prob_3;
	assign sup_in[0]  = support_0;
	assign sup_in[1]  = support_1;
	assign sup_in[2]  = support_2;
	assign sup_in[3]  = support_3;

	// a stage loads when it is empty or its successor loads
	always_comb begin
		rdy[NP] = !out_valid || !out_stall;
		for (int i = NP - 1; i >= 0; i--) begin
			rdy[i] = !vld_q[i] || rdy[i+1];
		end
	end

	assign in_stall  = !rdy[0];
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (rdy[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int i = 1; i < NP; i++) begin
				if (rdy[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
			if (rdy[NP]) begin
				out_valid <= vld_q[NP-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dens_q <= '0;
		end else if (cfg_valid && cfg_ready
			&& cfg_index < rlu_pkg::CFG_IDX_W'(NC)) begin
			dens_q[cfg_index[rlu_pkg::CLS_W-1:0]] <= cfg_data;
		end
	end

	for (genvar m = 0; m < NC; m++) begin : g_lane
		rlu_weight u_weight (
			.clk       (clk),
			.en        (rdy[0]),
			.prob      (prob_in[m]),
			.support   (sup_in[m]),
			.weight_s1 (w_s1[m])
		);

		rlu_div u_div (
			.clk    (clk),
			.en     (rdy[2 +: ND]),
			.weight (w_s2[m]),
			.sum    (sum_s2),
			.quo    (quo[m])
		);
	end

	always_comb begin
		sum_s1 = '0;
		for (int m = 0; m < NC; m++) begin
			sum_s1 = sum_s1 + rlu_pkg::SUM_W'(w_s1[m]);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			w_s2    <= w_s1;
			sum_s2  <= sum_s1;
			zero_s2 <= (sum_s1 == '0);
		end
		if (rdy[2]) begin
			zero_div_s[0] <= zero_s2;
		end
		for (int k = 1; k < ND; k++) begin
			if (rdy[2+k]) begin
				zero_div_s[k] <= zero_div_s[k-1];
			end
		end
		if (rdy[NP]) begin
			res_q <= merged;
		end
	end

	rlu_merge u_merge (
		.quo  (quo),
		.zero (zero_div_s[ND-1]),
		.dens (dens_q),
		.res  (merged)
	);

	assign new_prob_0  = res_q.prob[0];
	assign new_prob_1  = res_q.prob[1];
	assign new_prob_2  = res_q.prob[2];
	assign new_prob_3  = res_q.prob[3];
	assign best_class  = res_q.best;
	assign density_out = res_q.density;
	assign zero_sum    = res_q.zero;

	always_comb begin
		best_ok = 1'b1;
		for (int m = 0; m < NC; m++) begin
			if (res_q.prob[m] > res_q.prob[res_q.best]) begin
				best_ok = 1'b0;
			end
		end
	end

	ap_zero_forced: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_sum |-> best_class == '0 && res_q.prob == '0)
		else $error("zero sum result not forced");

	ap_best_is_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !zero_sum |-> best_ok)
		else $error("best class is not a maximum");

	ap_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> vld_q[0])
		else $error("accepted beat lost at pipeline entry");

	ap_tail_holds: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[NP-1] && !rdy[NP] |=> vld_q[NP-1])
		else $error("stalled pipeline tail dropped");

endmodule

FILE: rtl/rlu_weight.sv
module rlu_weight (
	input  logic                clk,
	input  logic                en,
	input  rlu_pkg::prob_t      prob,
	input  rlu_pkg::sup_t       support,
	output rlu_pkg::weight_t    weight_s1
);

	rlu_pkg::fact_t                                   factor;
	logic [rlu_pkg::PROB_W+rlu_pkg::FACT_W-1:0]       prod;

	assign factor = rlu_pkg::clamp_factor(support);
	assign prod   = {{rlu_pkg::FACT_W{1'b0}}, prob} * {{rlu_pkg::PROB_W{1'b0}}, factor};

	always_ff @(posedge clk) begin
		if (en) begin
			weight_s1 <= prod[rlu_pkg::WEIGHT_W-1:0];
		end
	end

endmodule

FILE: rtl/rlu_div.sv
module rlu_div (
	input  logic                              clk,
	input  logic [rlu_pkg::DIV_STAGES-1:0]    en,
	input  rlu_pkg::weight_t                  weight,
	input  rlu_pkg::sum_t                     sum,
	output rlu_pkg::prob_t                    quo
);

	localparam int SW = rlu_pkg::SUM_W;
	localparam int QW = rlu_pkg::QUO_W;
	localparam int NS = rlu_pkg::DIV_STAGES;

	logic [SW-1:0] rem_s [NS];
	logic [SW-1:0] den_s [NS];
	logic [QW-1:0] quo_s [NS];

	for (genvar k = 0; k < NS; k++) begin : g_step
		logic [SW:0]   trial;
		logic [SW:0]   diff;
		logic [SW-1:0] den_in;
		logic [QW-1:0] quo_in;
		logic          take;

		if (k == 0) begin : g_first
			assign trial  = {{(SW + 1 - rlu_pkg::WEIGHT_W){1'b0}}, weight};
			assign den_in = sum;
			assign quo_in = '0;
		end else begin : g_next
			assign trial  = {rem_s[k-1], 1'b0};
			assign den_in = den_s[k-1];
			assign quo_in = quo_s[k-1];
		end

		assign take = trial >= {1'b0, den_in};
		assign diff = trial - {1'b0, den_in};

		always_ff @(posedge clk) begin
			if (en[k]) begin
				rem_s[k] <= take ? diff[SW-1:0] : trial[SW-1:0];
				den_s[k] <= den_in;
				quo_s[k] <= {quo_in[QW-2:0], take};
			end
		end
	end

	// a quotient of exactly one saturates
	assign quo = quo_s[NS-1][QW-1] ? '1 : quo_s[NS-1][rlu_pkg::PROB_W-1:0];

endmodule

FILE: rtl/rlu_merge.sv
module rlu_merge (
	input  rlu_pkg::prob_vec_t  quo,
	input  logic                zero,
	input  rlu_pkg::dens_vec_t  dens,
	output rlu_pkg::result_t    res
);

	rlu_pkg::cls_t  best;
	rlu_pkg::prob_t best_val;

	always_comb begin
		best     = '0;
		best_val = '0;
		for (int m = 0; m < rlu_pkg::CLASSES; m++) begin
			if (quo[m] > best_val) begin
				best_val = quo[m];
				best     = rlu_pkg::CLS_W'(m);
			end
		end
		if (zero) begin
			res.prob    = '0;
			res.best    = '0;
			res.density = dens[0];
			res.zero    = 1'b1;
		end else begin
			res.prob    = quo;
			res.best    = best;
			res.density = dens[best];
			res.zero    = 1'b0;
		end
	end

endmodule
